@@ rtl/core/mcsp_pkg.sv @@
`default_nettype none

package mcsp_pkg;

	localparam int CHANNELS_DEF       = 16;
	localparam int POSITION_RANGE_DEF = 128;

	localparam int PIN_W   = 16;
	localparam int CH_W    = 4;
	localparam int POS_W   = 7;
	localparam int PHASE_W = 2;
	localparam int STEP_W  = 12;
	localparam int LEAD_W  = 8;
	localparam int SLOT_W  = 7;
	localparam int TAIL_W  = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PHASE_W-1:0] PHASE_LEAD = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_SLOT = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_TAIL = 2'd2;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAD_TICKS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL_TICKS    = 2'd3;

	localparam logic [PIN_W-1:0]  ENABLE_RST = 16'd0;
	localparam logic [LEAD_W-1:0] LEAD_RST   = 8'd29;
	localparam logic [SLOT_W-1:0] SLOT_RST   = 7'd115;
	localparam logic [TAIL_W-1:0] TAIL_RST   = 12'd1008;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [STEP_W-1:0]  step;
	} frame_t;

	typedef struct packed {
		logic [LEAD_W-1:0] lead_ticks;
		logic [SLOT_W-1:0] slot_count;
		logic [TAIL_W-1:0] tail_ticks;
	} frame_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/mcsp_if.sv @@
`default_nettype none

interface mcsp_item_if import mcsp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [CH_W-1:0]  channel;
	logic [POS_W-1:0] position;

	modport source (output valid, output action, output channel, output position, input ready);
	modport sink (input valid, input action, input channel, input position, output ready);
endinterface

interface mcsp_result_if import mcsp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIN_W-1:0]   pins;
	logic [PHASE_W-1:0] phase;

	modport source (output valid, output pins, output phase, input ready);
	modport sink (input valid, input pins, input phase, output ready);
endinterface

interface mcsp_cfg_if import mcsp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mcsp_frame_seq.sv @@
`default_nettype none

module mcsp_frame_seq import mcsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tick,
	input  wire frame_cfg_t frame_cfg,
	output frame_t          frame_next
);

	logic [PHASE_W-1:0] phase_q;
	logic [STEP_W-1:0]  step_q;
	logic [STEP_W-1:0]  step_inc;
	logic [STEP_W-1:0]  raw_len;
	logic [STEP_W-1:0]  phase_len;

	always_comb begin
		case (phase_q)
			PHASE_LEAD: raw_len = STEP_W'(frame_cfg.lead_ticks);
			PHASE_SLOT: raw_len = STEP_W'(frame_cfg.slot_count);
			default:    raw_len = frame_cfg.tail_ticks;
		endcase
		phase_len = (raw_len == '0) ? STEP_W'(1) : raw_len;
		step_inc  = step_q + STEP_W'(1);
	end

	always_comb begin
		frame_next.phase = phase_q;
		frame_next.step  = step_q;
		if (tick) begin
			if (phase_q != PHASE_LEAD && phase_q != PHASE_SLOT && phase_q != PHASE_TAIL) begin
				frame_next.phase = PHASE_LEAD;
				frame_next.step  = '0;
			end else if (step_inc >= phase_len) begin
				frame_next.step  = '0;
				frame_next.phase = (phase_q == PHASE_TAIL) ? PHASE_LEAD
					: phase_q + PHASE_W'(1);
			end else begin
				frame_next.step = step_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_LEAD;
			step_q  <= '0;
		end else begin
			phase_q <= frame_next.phase;
			step_q  <= frame_next.step;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/multi_channel_servo_pwm.sv @@
// datapath: an accepted transaction passes the input register, then the result register
// throughput: one transaction per cycle while results are taken; result register
// and input register decouple the two sides so either can stall without a bubble
// reset: asynchronous active low; frame starts in the lead phase at step zero,
// positions zero, outputs disabled, phase lengths at their default values
`default_nettype none

module multi_channel_servo_pwm import mcsp_pkg::*; #(
	parameter int CHANNELS       = CHANNELS_DEF,
	parameter int POSITION_RANGE = POSITION_RANGE_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mcsp_item_if.sink     item_in,
	mcsp_result_if.source result_out,
	mcsp_cfg_if.sink      cfg
);

	localparam int NPIN   = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;
	localparam int STO_W  = (POSITION_RANGE >= (1 << POS_W)) ? POS_W : $clog2(POSITION_RANGE);
	localparam int SAT_W  = 11;
	localparam logic [SAT_W-1:0] POS_MAX = SAT_W'(POSITION_RANGE - 1);

	logic [PIN_W-1:0] enable_q;
	frame_cfg_t       frame_cfg_q;

	logic             valid_s1;
	logic             action_s1;
	logic [CH_W-1:0]  channel_s1;
	logic [POS_W-1:0] position_s1;

	logic               out_valid_q;
	logic [PIN_W-1:0]   pins_q;
	logic [PHASE_W-1:0] phase_q;

	logic [STO_W-1:0] pos_q [NPIN];
	logic [STO_W-1:0] pos_sat;
	logic             advance;
	logic             wr_s1;
	frame_t           frame_next;
	logic [PIN_W-1:0] pins_next;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= ENABLE_RST;
			frame_cfg_q <= '{lead_ticks: LEAD_RST, slot_count: SLOT_RST, tail_ticks: TAIL_RST};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_OUTPUT_ENABLE: enable_q <= cfg.data;
				CFG_LEAD_TICKS:    frame_cfg_q.lead_ticks <= cfg.data[LEAD_W-1:0];
				CFG_SLOT_COUNT:    frame_cfg_q.slot_count <= cfg.data[SLOT_W-1:0];
				CFG_TAIL_TICKS:    frame_cfg_q.tail_ticks <= cfg.data[TAIL_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			action_s1   <= item_in.action;
			channel_s1  <= item_in.channel;
			position_s1 <= item_in.position;
		end
	end

	mcsp_frame_seq u_frame_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (advance && action_s1 == ACT_TICK),
		.frame_cfg  (frame_cfg_q),
		.frame_next (frame_next)
	);

	assign wr_s1 = advance && action_s1 == ACT_WRITE;

	always_comb begin
		if (SAT_W'(position_s1) > POS_MAX) begin
			pos_sat = STO_W'(POS_MAX);
		end else begin
			pos_sat = STO_W'(position_s1);
		end
	end

	// position store and per channel compare against the step after this transaction
	always_comb begin
		pins_next = '0;
		for (int n = 0; n < NPIN; n++) begin
			logic [STO_W-1:0] pos_eff;
			pos_eff = (wr_s1 && channel_s1 == CH_W'(n)) ? pos_sat : pos_q[n];
			if (frame_next.phase == PHASE_LEAD) begin
				pins_next[n] = 1'b1;
			end else if (frame_next.phase == PHASE_SLOT) begin
				pins_next[n] = frame_next.step < STEP_W'(pos_eff);
			end
		end
		pins_next = pins_next & enable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NPIN; n++) begin
				pos_q[n] <= '0;
			end
		end else if (wr_s1) begin
			for (int n = 0; n < NPIN; n++) begin
				if (channel_s1 == CH_W'(n)) begin
					pos_q[n] <= pos_sat;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pins_q  <= pins_next;
			phase_q <= frame_next.phase;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.pins  = pins_q;
	assign result_out.phase = phase_q;

endmodule

`default_nettype wire

@@ sim/multi_channel_servo_pwm_test.sv @@
`timescale 1ns / 1ps

module multi_channel_servo_pwm_test;
	import mcsp_pkg::*;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic                  act;
		logic [CH_W-1:0]       ch;
		logic [POS_W-1:0]      pos;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  known;
		logic [PIN_W-1:0]      pins;
		logic [PHASE_W-1:0]    phase;
	} stim_row_t;

	typedef struct packed {
		logic [PIN_W-1:0]   pins;
		logic [PHASE_W-1:0] phase;
	} servo_out_t;

	localparam int NROWS = 35;

	stim_row_t dir_rows [NROWS] = '{
		'{ROW_ITEM, ACT_WRITE, 4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'h0000, PHASE_LEAD},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'hffff, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd3,  7'd9,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'hffff, PHASE_LEAD},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_LEAD_TICKS,    16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_WRITE, 4'd15, 7'd127, CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'hffff, PHASE_LEAD},
		'{ROW_ITEM, ACT_WRITE, 4'd0,  7'd1,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'hffff, PHASE_LEAD},
		'{ROW_ITEM, ACT_WRITE, 4'd5,  7'd3,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd15, 7'd127, CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'h8021, PHASE_SLOT},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'h8020, PHASE_SLOT},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_SLOT_COUNT,    16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'h0000, PHASE_TAIL},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_TAIL_TICKS,    16'h0fff, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'h0000, PHASE_TAIL},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_TAIL_TICKS,    16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'hffff, PHASE_LEAD},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'ha5a5, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_LEAD_TICKS,    16'h00ff, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'ha5a5, PHASE_LEAD},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_LEAD_TICKS,    16'h0001, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_SLOT_COUNT,    16'h007f, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b1, 16'h8021, PHASE_SLOT},
		'{ROW_ITEM, ACT_WRITE, 4'd2,  7'd127, CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_WRITE, 4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_WRITE, 4'd9,  7'h55,  CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_WRITE, 4'd6,  7'h2a,  CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h5a5a, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_TAIL_TICKS,    16'h0001, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_REG,  ACT_TICK,  4'd0,  7'd0,   CFG_SLOT_COUNT,    16'h0003, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD},
		'{ROW_ITEM, ACT_TICK,  4'd0,  7'd0,   CFG_OUTPUT_ENABLE, 16'h0000, 1'b0, 16'h0000, PHASE_LEAD}
	};

	logic clk = 1'b0;
	logic arst_n;

	mcsp_item_if   item_bus ();
	mcsp_result_if result_bus ();
	mcsp_cfg_if    cfg_bus ();

	multi_channel_servo_pwm u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_bus.sink),
		.result_out (result_bus.source),
		.cfg        (cfg_bus.sink)
	);

	always #5 clk = ~clk;

	// frame predictor state
	logic [PIN_W-1:0]   en_mask;
	logic [LEAD_W-1:0]  lead_len;
	logic [SLOT_W-1:0]  slot_len;
	logic [TAIL_W-1:0]  tail_len;
	logic [POS_W-1:0]   pos_mem [CHANNELS_DEF];
	logic [PHASE_W-1:0] fr_phase;
	logic [STEP_W-1:0]  fr_step;

	servo_out_t servo_out_q [$];
	int mismatches = 0;
	int items_sent = 0;
	int send_quiet = 0;
	int recv_quiet = 0;

	function automatic int pick_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic servo_out_t advance_servo(input logic act, input logic [CH_W-1:0] ch,
			input logic [POS_W-1:0] pos);
		servo_out_t r;
		logic [STEP_W-1:0] len;
		if (act == ACT_TICK) begin
			if (fr_phase > PHASE_TAIL) begin
				fr_phase = PHASE_LEAD;
				fr_step = '0;
			end else begin
				case (fr_phase)
					PHASE_LEAD: len = STEP_W'(lead_len);
					PHASE_SLOT: len = STEP_W'(slot_len);
					default: len = tail_len;
				endcase
				if (len == '0)
					len = STEP_W'(1);
				fr_step = fr_step + 1'b1;
				if (fr_step >= len) begin
					fr_step = '0;
					fr_phase = (fr_phase == PHASE_TAIL) ? PHASE_LEAD : fr_phase + 1'b1;
				end
			end
		end else begin
			pos_mem[ch] = pos;
		end
		r.pins = '0;
		if (fr_phase == PHASE_LEAD) begin
			r.pins = '1;
		end else if (fr_phase == PHASE_SLOT) begin
			for (int n = 0; n < CHANNELS_DEF; n++)
				r.pins[n] = (fr_step < STEP_W'(pos_mem[n]));
		end
		r.pins = r.pins & en_mask;
		r.phase = fr_phase;
		return r;
	endfunction

	task automatic push_item(input logic act, input logic [CH_W-1:0] ch,
			input logic [POS_W-1:0] pos, input logic known, input logic [PIN_W-1:0] kpins,
			input logic [PHASE_W-1:0] kphase);
		int gap;
		servo_out_t r;
		gap = pick_wait(send_quiet);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid    <= 1'b1;
		item_bus.action   <= act;
		item_bus.channel  <= ch;
		item_bus.position <= pos;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		r = advance_servo(act, ch, pos);
		if (known) begin
			r.pins = kpins;
			r.phase = kphase;
		end
		servo_out_q.push_back(r);
		items_sent++;
	endtask

	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		while (servo_out_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_OUTPUT_ENABLE: en_mask = data[PIN_W-1:0];
			CFG_LEAD_TICKS:    lead_len = data[LEAD_W-1:0];
			CFG_SLOT_COUNT:    slot_len = data[SLOT_W-1:0];
			default:           tail_len = data[TAIL_W-1:0];
		endcase
	endtask

	task automatic pick_setting();
		logic [PIN_W-1:0]  v_en;
		logic [LEAD_W-1:0] v_lead;
		logic [SLOT_W-1:0] v_slot;
		logic [TAIL_W-1:0] v_tail;
		logic dirty;
		case ($urandom_range(0, 3))
			0: v_en = '1;
			1: v_en = '0;
			default: v_en = PIN_W'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: begin
				v_lead = LEAD_W'(1); v_slot = SLOT_W'(1); v_tail = TAIL_W'(1);
			end
			1: begin
				v_lead = '0; v_slot = '0; v_tail = '0;
			end
			2: begin
				v_lead = '1; v_slot = '1; v_tail = '1;
			end
			3: begin
				v_lead = LEAD_RST; v_slot = SLOT_RST; v_tail = TAIL_RST;
			end
			default: begin
				v_lead = LEAD_W'($urandom_range(1, 8));
				v_slot = SLOT_W'($urandom_range(1, 40));
				v_tail = TAIL_W'($urandom_range(1, 12));
			end
		endcase
		dirty = 1'($urandom_range(0, 1));
		write_reg(CFG_OUTPUT_ENABLE, v_en);
		write_reg(CFG_LEAD_TICKS, {dirty ? 8'($urandom) : 8'h00, v_lead});
		write_reg(CFG_SLOT_COUNT, {dirty ? 9'($urandom) : 9'h000, v_slot});
		write_reg(CFG_TAIL_TICKS, {dirty ? 4'($urandom) : 4'h0, v_tail});
	endtask

	initial begin
		result_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			servo_out_t want;
			stall = pick_wait(recv_quiet);
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (result_bus.valid !== 1'b1);
			if (servo_out_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: pins %h phase %0d",
						result_bus.pins, result_bus.phase);
			end else begin
				want = servo_out_q.pop_front();
				if (result_bus.pins !== want.pins || result_bus.phase !== want.phase) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: pins exp %h got %h, phase exp %0d got %0d",
							want.pins, result_bus.pins, want.phase, result_bus.phase);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("multi_channel_servo_pwm_test: errors");
		$finish;
	end

	initial begin
		int n;
		logic act;
		logic [POS_W-1:0] pos;
		item_bus.valid    = 1'b0;
		item_bus.action   = ACT_TICK;
		item_bus.channel  = '0;
		item_bus.position = '0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.index     = CFG_OUTPUT_ENABLE;
		cfg_bus.data      = '0;
		arst_n            = 1'b0;
		en_mask  = ENABLE_RST;
		lead_len = LEAD_RST;
		slot_len = SLOT_RST;
		tail_len = TAIL_RST;
		foreach (pos_mem[i])
			pos_mem[i] = '0;
		fr_phase = PHASE_LEAD;
		fr_step  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				push_item(dir_rows[i].act, dir_rows[i].ch, dir_rows[i].pos,
					dir_rows[i].known, dir_rows[i].pins, dir_rows[i].phase);
			end
		end

		while (items_sent < NROWS + 800) begin
			wait_idle();
			pick_setting();
			n = $urandom_range(40, 100);
			repeat (n) begin
				act = ($urandom_range(0, 9) < 7) ? ACT_TICK : ACT_WRITE;
				case ($urandom_range(0, 5))
					0: pos = '0;
					1: pos = '1;
					2: pos = slot_len - 7'd1 + 7'($urandom_range(0, 2));
					default: pos = POS_W'($urandom);
				endcase
				push_item(act, CH_W'($urandom), pos, 1'b0, '0, PHASE_LEAD);
			end
		end

		wait_idle();
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("multi_channel_servo_pwm_test: clean");
		else
			$display("multi_channel_servo_pwm_test: errors");
		$finish;
	end

endmodule
